// File: sv/ttnl_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the numeric-literal text tokenizer.
// No dependencies; imported by text_tokenizer_numeric_literals.
package ttnl_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } tok_in_t;

  typedef struct packed {
    logic [7:0] tok_char;
    logic       tok_first;
    logic       tok_last;
    logic [1:0] tok_kind;
    logic       line_error;
  } tok_out_t;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_NUM  = 2'd1,
    KIND_OP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    EXP_NONE     = 2'd0,
    EXP_UNSIGNED = 2'd1,
    EXP_SIGNED   = 2'd2
  } exp_mode_t;

  // result of testing one byte against the number grammar
  typedef struct packed {
    logic      ok;
    logic      dot;
    exp_mode_t expm;
  } num_res_t;

  localparam logic [15:0] MAX_LEN_RESET = 16'd65534;
  localparam int          OUT_DEPTH     = 4;
  localparam int          OUT_PTR_W     = $clog2(OUT_DEPTH);
  localparam int          OUT_CNT_W     = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LO_E   = 8'h65;

endpackage

// File: sv/text_tokenizer_numeric_literals.sv
`timescale 1ns / 1ps
// Streaming tokenizer: marks words, number literals and operators in a byte stream.
// Depends on ttnl_pkg for payload types, token kinds and character constants.
//
//   channel | ports                        | moves
//   --------+------------------------------+----------------------------------
//   input   | in_valid  in_stall  in_data  | one raw byte or end-of-stream mark
//   output  | out_valid out_stall out_data | one token character with flags
//   config  | cfg_wr_en cfg_wr_data        | max_line_len, 16 bits
//
// An item is classified when the item after it is accepted; one item per clock
// while in_stall is low. Results leave through a 4-entry queue, one per clock
// while out_stall is low; an end-of-stream item can leave two results.
// in_stall rises only when the queue holds more than two results.
// rst_n is synchronous; it clears the lookahead, the error flag and the queue
// and loads max_line_len with 65534.
module text_tokenizer_numeric_literals
  import ttnl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tok_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tok_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_FF) || (c == CH_NL) ||
           (c == CH_CR) || (c == CH_TAB) || (c == CH_VT);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_COLON) ||
           (c == CH_LT) || (c == CH_GT) || (c == CH_EQ);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  // does c extend a number, given the byte nx after it; flags only move on ok
  function automatic num_res_t num_char(input logic [7:0] c, input logic [7:0] nx,
                                        input logic first, input logic dot,
                                        input exp_mode_t expm);
    num_res_t res;
    res.ok   = 1'b0;
    res.dot  = dot;
    res.expm = expm;
    if (is_digit(c)) begin
      res.ok = 1'b1;
    end else if ((expm == EXP_NONE) && !dot && (c == CH_DOT)) begin
      res.ok  = 1'b1;
      res.dot = 1'b1;
    end else if (!first && (expm == EXP_NONE) && ((c == CH_LO_E) || (c == CH_UP_E))) begin
      if (is_sign(nx)) begin
        res.ok   = 1'b1;
        res.expm = EXP_SIGNED;
      end else if (is_digit(nx)) begin
        res.ok   = 1'b1;
        res.expm = EXP_UNSIGNED;
      end
    end else if ((expm == EXP_SIGNED) && is_sign(c)) begin
      res.ok   = 1'b1;
      res.expm = EXP_UNSIGNED;
    end
    return res;
  endfunction

  // tokenizer state
  logic [15:0] max_len_r,  max_len_nxt;
  logic [7:0]  la0_r,      la0_nxt;
  logic [7:0]  la1_r,      la1_nxt;
  logic        la1_vld_r,  la1_vld_nxt;
  logic        in_tok_r,   in_tok_nxt;
  logic        wf_r,       wf_nxt;
  kind_t       kind_r,     kind_nxt;
  logic        dot_r,      dot_nxt;
  exp_mode_t   exp_r,      exp_nxt;
  logic        cmt_r,      cmt_nxt;
  logic [15:0] line_len_r, line_len_nxt;
  logic        err_r,      err_nxt;

  // result queue
  tok_out_t               q_mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0]   cnt_r;

  logic        in_acc, out_acc;
  logic        is_nl, cmt_c;
  logic [7:0]  eff;
  logic [16:0] len_inc;
  logic        too_long;
  logic [7:0]  r_byte;

  // classification of the waiting byte
  logic        c_emit;
  tok_out_t    c_item;
  logic        c_in, c_wf, c_dot, c_start;
  logic [7:0]  c_chr;
  kind_t       c_kind;
  exp_mode_t   c_exp;
  num_res_t    nr_cont, nr_first;

  logic        e0_vld, e1_vld;
  tok_out_t    e0, e1, slot0;
  logic [1:0]  n_push;

  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (cnt_r > OUT_CNT_W'(OUT_DEPTH - 2));
  assign out_data  = q_mem_r[rd_ptr_r];

  // comment stripping and line length
  assign is_nl    = (in_data.char_in == CH_NL);
  assign cmt_c    = !is_nl && ((in_data.char_in == CH_BSLASH) || cmt_r);
  assign eff      = cmt_c ? CH_NUL : in_data.char_in;
  assign len_inc  = {1'b0, line_len_r} + 17'd1;
  assign too_long = (len_inc > {1'b0, max_len_r});
  assign r_byte   = in_data.end_of_input ? CH_NUL : eff;

  assign nr_cont  = num_char(la1_r, r_byte, 1'b0, dot_r, exp_r);
  assign nr_first = num_char(la1_r, r_byte, 1'b1, 1'b0, EXP_NONE);

  always_comb begin
    c_emit  = 1'b0;
    c_item  = '0;
    c_in    = in_tok_r;
    c_chr   = la0_r;
    c_wf    = wf_r;
    c_kind  = kind_r;
    c_dot   = dot_r;
    c_exp   = exp_r;
    c_start = 1'b0;
    if (la1_vld_r) begin
      c_start = 1'b1;
      if (in_tok_r) begin
        case (kind_r)
          KIND_NUM: begin
            if (nr_cont.ok) begin
              c_emit  = 1'b1;
              c_item  = '{la0_r, wf_r, 1'b0, KIND_NUM, 1'b0};
              c_chr   = la1_r;
              c_wf    = 1'b0;
              c_dot   = nr_cont.dot;
              c_exp   = nr_cont.expm;
              c_start = 1'b0;
            end
          end
          KIND_WORD: begin
            if (!is_delim(la1_r) && !is_op(la1_r)) begin
              c_emit  = 1'b1;
              c_item  = '{la0_r, wf_r, 1'b0, KIND_WORD, 1'b0};
              c_chr   = la1_r;
              c_wf    = 1'b0;
              c_start = 1'b0;
            end
          end
          KIND_OP: begin
            // absorb a trailing '=', fold '=<' and '=>' into '<' and '>'
            if (((la0_r == CH_LT) || (la0_r == CH_GT) || (la0_r == CH_EQ)) &&
                (la1_r == CH_EQ)) begin
              c_emit  = 1'b1;
              c_item  = '{la0_r, wf_r, 1'b1, KIND_OP, 1'b0};
              c_in    = 1'b0;
              c_wf    = 1'b0;
              c_start = 1'b0;
            end else if ((la0_r == CH_EQ) && ((la1_r == CH_LT) || (la1_r == CH_GT))) begin
              c_emit  = 1'b1;
              c_item  = '{la1_r, wf_r, 1'b1, KIND_OP, 1'b0};
              c_in    = 1'b0;
              c_wf    = 1'b0;
              c_start = 1'b0;
            end
          end
          default: ;
        endcase
        if (c_start) begin
          c_emit = 1'b1;
          c_item = '{la0_r, wf_r, 1'b1, kind_r, 1'b0};
          c_in   = 1'b0;
          c_wf   = 1'b0;
        end
      end
      if (c_start && !is_delim(la1_r)) begin
        c_in  = 1'b1;
        c_chr = la1_r;
        c_wf  = 1'b1;
        c_dot = nr_first.dot;
        c_exp = nr_first.expm;
        if (nr_first.ok) begin
          c_kind = KIND_NUM;
        end else if (is_op(la1_r)) begin
          c_kind = KIND_OP;
        end else begin
          c_kind = KIND_WORD;
        end
      end
    end
  end

  always_comb begin
    max_len_nxt  = cfg_wr_en ? cfg_wr_data : max_len_r;
    la0_nxt      = la0_r;
    la1_nxt      = la1_r;
    la1_vld_nxt  = la1_vld_r;
    in_tok_nxt   = in_tok_r;
    wf_nxt       = wf_r;
    kind_nxt     = kind_r;
    dot_nxt      = dot_r;
    exp_nxt      = exp_r;
    cmt_nxt      = cmt_r;
    line_len_nxt = line_len_r;
    err_nxt      = err_r;
    e0_vld       = 1'b0;
    e1_vld       = 1'b0;
    e0           = '0;
    e1           = '0;
    if (in_acc) begin
      if (err_r) begin
        e0_vld = 1'b1;
        e0     = '{8'd0, 1'b0, 1'b0, 2'd0, 1'b1};
      end else if (in_data.end_of_input) begin
        // flush both lookahead bytes, mark the last pending char as last
        e0_vld = c_emit;
        e0     = c_item;
        e1_vld = c_in;
        e1     = '{c_chr, c_wf, 1'b1, c_kind, 1'b0};
        la0_nxt      = '0;
        la1_nxt      = '0;
        la1_vld_nxt  = 1'b0;
        in_tok_nxt   = 1'b0;
        wf_nxt       = 1'b0;
        kind_nxt     = KIND_WORD;
        dot_nxt      = 1'b0;
        exp_nxt      = EXP_NONE;
        cmt_nxt      = 1'b0;
        line_len_nxt = '0;
      end else if (too_long) begin
        err_nxt     = 1'b1;
        e0_vld      = 1'b1;
        e0          = '{8'd0, 1'b0, 1'b0, 2'd0, 1'b1};
        la0_nxt     = '0;
        la1_nxt     = '0;
        la1_vld_nxt = 1'b0;
        in_tok_nxt  = 1'b0;
        wf_nxt      = 1'b0;
        kind_nxt    = KIND_WORD;
        dot_nxt     = 1'b0;
        exp_nxt     = EXP_NONE;
      end else begin
        line_len_nxt = is_nl ? 16'd0 : len_inc[15:0];
        cmt_nxt      = cmt_c;
        e0_vld       = c_emit;
        e0           = c_item;
        la0_nxt      = c_chr;
        in_tok_nxt   = c_in;
        wf_nxt       = c_wf;
        kind_nxt     = c_kind;
        dot_nxt      = c_dot;
        exp_nxt      = c_exp;
        la1_nxt      = eff;
        la1_vld_nxt  = 1'b1;
      end
    end
  end

  // pack the results of this item into consecutive queue slots
  assign slot0  = e0_vld ? e0 : e1;
  assign n_push = {1'b0, e0_vld} + {1'b0, e1_vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= MAX_LEN_RESET;
      la0_r      <= '0;
      la1_r      <= '0;
      la1_vld_r  <= 1'b0;
      in_tok_r   <= 1'b0;
      wf_r       <= 1'b0;
      kind_r     <= KIND_WORD;
      dot_r      <= 1'b0;
      exp_r      <= EXP_NONE;
      cmt_r      <= 1'b0;
      line_len_r <= '0;
      err_r      <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      max_len_r  <= max_len_nxt;
      la0_r      <= la0_nxt;
      la1_r      <= la1_nxt;
      la1_vld_r  <= la1_vld_nxt;
      in_tok_r   <= in_tok_nxt;
      wf_r       <= wf_nxt;
      kind_r     <= kind_nxt;
      dot_r      <= dot_nxt;
      exp_r      <= exp_nxt;
      cmt_r      <= cmt_nxt;
      line_len_r <= line_len_nxt;
      err_r      <= err_nxt;
      wr_ptr_r   <= wr_ptr_r + OUT_PTR_W'(n_push);
      rd_ptr_r   <= rd_ptr_r + OUT_PTR_W'(out_acc);
      cnt_r      <= cnt_r + OUT_CNT_W'(n_push) - OUT_CNT_W'(out_acc);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem_r[wr_ptr_r] <= slot0;
    end
    if (n_push == 2'd2) begin
      q_mem_r[wr_ptr_r + OUT_PTR_W'(1)] <= e1;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("line error flag cleared without reset");

  a_err_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && err_r) |-> (n_push == 2'd1))
    else $error("item in error state must give exactly one result");

  // the error state keeps its line count, so only check outside it
  a_eoi_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.end_of_input && !err_r) |=>
      (!in_tok_r && !la1_vld_r && line_len_r == '0))
    else $error("end of stream did not clear the lookahead");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for text_tokenizer_numeric_literals: directed and random byte streams,
// tokenized by a model kept here, with every token character checked in order.
// Depends on ttnl_pkg and the tokenizer RTL.
module tb;
  import ttnl_pkg::*;

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          SETTLE      = 8;
  localparam logic [7:0]  CH_LO_A     = 8'h61;
  localparam logic [7:0]  CH_UP_A     = 8'h41;
  localparam logic [7:0]  CH_LO_Q     = 8'h71;

  class tok_scoreboard;
    logic [15:0] max_len;
    logic [7:0]  held_char;   // token char waiting for its last flag
    logic [7:0]  next_char;   // raw byte waiting for its class
    bit          next_ok;
    bit          in_tok;
    kind_t       tkind;
    bit          seen_dot;
    exp_mode_t   expm;
    bit          in_cmt;
    logic [15:0] line_len;
    bit          err;
    bit          held_first;
    tok_out_t    pending_chars[$];
    int          n_chars;
    int          n_errs;
    int          n_fail;

    function new();
      max_len = MAX_LEN_RESET;
      clear_pipe();
      in_cmt   = 0;
      line_len = 16'd0;
      err      = 0;
      n_chars  = 0;
      n_errs   = 0;
      n_fail   = 0;
    endfunction

    function void clear_pipe();
      held_char  = CH_NUL;
      next_char  = CH_NUL;
      next_ok    = 0;
      in_tok     = 0;
      tkind      = KIND_WORD;
      seen_dot   = 0;
      expm       = EXP_NONE;
      held_first = 0;
    endfunction

    function bit is_delim(logic [7:0] c);
      return c == CH_NUL || c == CH_SPACE || c == CH_FF || c == CH_NL || c == CH_CR ||
             c == CH_TAB || c == CH_VT;
    endfunction

    function bit is_op(logic [7:0] c);
      return c == CH_MINUS || c == CH_PLUS || c == CH_COLON || c == CH_LT || c == CH_GT ||
             c == CH_EQ;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_sign(logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS;
    endfunction

    // Does c extend a number, given the byte after it? Tracks dot and exponent.
    function bit num_char(logic [7:0] c, logic [7:0] nx, bit first);
      if (is_digit(c))
        return 1;
      if (expm == EXP_NONE && !seen_dot && c == CH_DOT) begin
        seen_dot = 1;
        return 1;
      end
      if (!first && expm == EXP_NONE && (c == CH_LO_E || c == CH_UP_E)) begin
        if (is_sign(nx)) begin
          expm = EXP_SIGNED;
          return 1;
        end
        if (is_digit(nx)) begin
          expm = EXP_UNSIGNED;
          return 1;
        end
        return 0;
      end
      if (expm == EXP_SIGNED && is_sign(c)) begin
        expm = EXP_UNSIGNED;
        return 1;
      end
      return 0;
    endfunction

    function void emit(logic [7:0] ch, bit first, bit last, kind_t kind, bit e);
      tok_out_t r;
      r.tok_char   = ch;
      r.tok_first  = first;
      r.tok_last   = last;
      r.tok_kind   = kind;
      r.line_error = e;
      pending_chars.push_back(r);
    endfunction

    function void hold_char(logic [7:0] q, bit first);
      held_char  = q;
      in_tok     = 1;
      held_first = first;
    endfunction

    function void close_token();
      in_tok     = 0;
      held_char  = CH_NUL;
      held_first = 0;
    endfunction

    // Classify byte q with successor r; may release the held character.
    function void classify(logic [7:0] q, logic [7:0] r);
      logic [7:0] p;
      if (in_tok) begin
        p = held_char;
        if (tkind == KIND_NUM) begin
          if (num_char(q, r, 0)) begin
            emit(p, held_first, 0, KIND_NUM, 0);
            hold_char(q, 0);
            return;
          end
        end else if (tkind == KIND_WORD) begin
          if (!is_delim(q) && !is_op(q)) begin
            emit(p, held_first, 0, KIND_WORD, 0);
            hold_char(q, 0);
            return;
          end
        end else if ((p == CH_LT || p == CH_GT || p == CH_EQ) && q == CH_EQ) begin
          emit(p, held_first, 1, KIND_OP, 0);
          close_token();
          return;
        end else if (p == CH_EQ && (q == CH_LT || q == CH_GT)) begin
          emit(q, held_first, 1, KIND_OP, 0);
          close_token();
          return;
        end
        emit(p, held_first, 1, tkind, 0);
        close_token();
      end
      if (is_delim(q))
        return;
      seen_dot = 0;
      expm     = EXP_NONE;
      if (num_char(q, r, 1))
        tkind = KIND_NUM;
      else if (is_op(q))
        tkind = KIND_OP;
      else
        tkind = KIND_WORD;
      hold_char(q, 1);
    endfunction

    // Note one accepted item and queue the token characters it releases.
    function void tokenize(tok_in_t it);
      logic [7:0]  c;
      logic [7:0]  eff;
      int unsigned len;
      if (err) begin
        emit(CH_NUL, 0, 0, KIND_WORD, 1);
        return;
      end
      if (it.end_of_input) begin
        if (next_ok)
          classify(next_char, CH_NUL);
        if (in_tok)
          emit(held_char, held_first, 1, tkind, 0);
        clear_pipe();
        in_cmt   = 0;
        line_len = 16'd0;
        return;
      end
      c   = it.char_in;
      len = line_len + 1;
      if (len > max_len) begin
        err = 1;
        clear_pipe();
        emit(CH_NUL, 0, 0, KIND_WORD, 1);
        return;
      end
      line_len = (c == CH_NL) ? 16'd0 : len[15:0];
      if (c == CH_NL) begin
        in_cmt = 0;
        eff    = c;
      end else begin
        if (c == CH_BSLASH)
          in_cmt = 1;
        eff = in_cmt ? CH_NUL : c;
      end
      if (next_ok)
        classify(next_char, eff);
      next_char = eff;
      next_ok   = 1;
    endfunction

    function void compare(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        n_fail++;
        if (n_fail <= 40)
          $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void check_char(tok_out_t got);
      tok_out_t want;
      if (pending_chars.size() == 0) begin
        n_fail++;
        if (n_fail <= 40)
          $display("%0t: token char expected none, got %h", $time, got);
        return;
      end
      want = pending_chars.pop_front();
      if (want.line_error)
        n_errs++;
      else
        n_chars++;
      compare("tok_char", want.tok_char, got.tok_char);
      compare("tok_first", want.tok_first, got.tok_first);
      compare("tok_last", want.tok_last, got.tok_last);
      compare("tok_kind", want.tok_kind, got.tok_kind);
      compare("line_error", want.line_error, got.line_error);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  tok_in_t     in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  tok_out_t    out_data;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  tok_scoreboard sb = new();

  bit gaps_on     = 1;
  bit stall_on    = 1;
  bit guard_lines = 1;
  int cur_limit   = MAX_LEN_RESET;
  int gen_line    = 0;
  int items_sent  = 0;
  int eoi_sent    = 0;
  int settings    = 0;
  int cycles      = 0;

  text_tokenizer_numeric_literals DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk)
    out_stall <= rst_n && stall_on && ($urandom_range(99) < 14);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall)
      sb.tokenize(in_data);
    if (rst_n && out_valid && !out_stall)
      sb.check_char(out_data);
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one item at a falling edge and hold it until accepted.
  task automatic drive_item(input tok_in_t it);
    while (gaps_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    if (it.end_of_input || it.char_in == CH_NL)
      gen_line = 0;
    else
      gen_line++;
  endtask

  task automatic send_eoi();
    tok_in_t it;
    it.char_in      = 8'($urandom_range(255));
    it.end_of_input = 1'b1;
    eoi_sent++;
    drive_item(it);
  endtask

  // Break the line first when the byte would push it past the limit.
  task automatic send_char(input logic [7:0] c);
    tok_in_t it;
    if (guard_lines && gen_line + ((c == CH_NL) ? 1 : 2) > cur_limit) begin
      if (cur_limit >= 2 && c != CH_NL) begin
        it.char_in      = CH_NL;
        it.end_of_input = 1'b0;
        drive_item(it);
      end else begin
        send_eoi();
      end
    end
    it.char_in      = c;
    it.end_of_input = 1'b0;
    drive_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i]);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.max_len = v;
    cur_limit  = v;
    settings++;
  endtask

  // Hold the sender until every queued token char is out, then settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_chars.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(5))
      0: return CH_MINUS;
      1: return CH_PLUS;
      2: return CH_COLON;
      3: return CH_LT;
      4: return CH_GT;
      default: return CH_EQ;
    endcase
  endfunction

  function automatic logic [7:0] rand_delim();
    case ($urandom_range(11))
      0: return CH_TAB;
      1: return CH_NL;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      5: return CH_NUL;
      default: return CH_SPACE;
    endcase
  endfunction

  // Append one token-shaped fragment: mostly well-formed, some broken or noise.
  function automatic void make_piece(ref logic [7:0] q[$]);
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1: begin
        repeat ($urandom_range(1, 4)) q.push_back(rand_digit());
        if ($urandom_range(1)) begin
          q.push_back(CH_DOT);
          repeat ($urandom_range(3)) q.push_back(rand_digit());
        end
        if ($urandom_range(2) == 0) begin
          q.push_back($urandom_range(1) ? CH_LO_E : CH_UP_E);
          if ($urandom_range(1))
            q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
          repeat ($urandom_range(2)) q.push_back(rand_digit());
        end
      end
      2, 3: begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(3))
            0, 1: q.push_back(CH_LO_A + 8'($urandom_range(25)));
            2: q.push_back(CH_UP_A + 8'($urandom_range(25)));
            default: q.push_back(8'($urandom_range(128, 255)));
          endcase
        end
      end
      4: repeat ($urandom_range(1, 2)) q.push_back(rand_op());
      5, 6: q.push_back(rand_delim());
      7: begin
        q.push_back(CH_BSLASH);
        repeat ($urandom_range(5)) begin
          b = 8'($urandom_range(255));
          q.push_back((b == CH_NL) ? CH_SPACE : b);
        end
        q.push_back(CH_NL);
      end
      8: repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(255)));
      default: begin
        repeat ($urandom_range(2, 6)) begin
          case ($urandom_range(4))
            0, 1: q.push_back(rand_digit());
            2: q.push_back(CH_DOT);
            3: q.push_back($urandom_range(1) ? CH_LO_E : CH_UP_E);
            default: q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
          endcase
        end
      end
    endcase
    if ($urandom_range(1))
      q.push_back(rand_delim());
  endfunction

  task automatic run_random(input int n_items, input bit mid_pause);
    logic [7:0] piece[$];
    int         start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      piece.delete();
      make_piece(piece);
      foreach (piece[i]) send_char(piece[i]);
      if ($urandom_range(99) < 5)
        send_eoi();
      if (mid_pause && items_sent - start >= n_items / 2) begin
        drain();
        mid_pause = 0;
      end else if ($urandom_range(199) == 0) begin
        drain();
      end
    end
    send_eoi();
  endtask

  initial begin
    logic [7:0] piece[$];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 16'd0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // signed exponent, high bytes, zero byte, merged operators, broken exponent,
    // comment, unsigned exponent flushed by end of stream
    write_limit(MAX_LEN_RESET);
    send_text("9.1e-2 ab");
    send_char(8'hFF);
    send_char(CH_NUL);
    send_text("<=:=>4Ex");
    send_char(CH_BSLASH);
    send_text("z");
    send_char(CH_NL);
    send_text("7e5");
    send_eoi();
    drain();

    // one-byte lines: every token is cut by an end-of-stream mark
    write_limit(16'd1);
    run_random(40, 0);
    drain();

    write_limit(16'd23);
    run_random(250, 1);
    drain();

    // back-to-back stretch, no gaps on either side
    gaps_on  = 0;
    stall_on = 0;
    write_limit(16'h5555);
    run_random(200, 0);
    drain();
    gaps_on  = 1;
    stall_on = 1;

    write_limit(MAX_LEN_RESET);
    run_random(250, 1);
    drain();

    // overrun the line limit, then keep feeding the stuck block
    write_limit(16'd30);
    guard_lines = 0;
    while (!sb.err) begin
      piece.delete();
      make_piece(piece);
      foreach (piece[i]) send_char((piece[i] == CH_NL) ? CH_LO_Q : piece[i]);
    end
    drain();
    write_limit(16'd0);
    run_random(60, 0);
    drain();

    $display("run: %0d items incl. %0d end-of-stream marks, %0d line limit settings",
             items_sent, eoi_sent, settings);
    $display("run: %0d token chars and %0d error results checked", sb.n_chars, sb.n_errs);
    if (sb.n_fail == 0 && sb.pending_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
